[design/tmot_pkg.sv]
// shared constants for the trimmed mean of twelve unit
package tmot_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int BLOCK_LEN       = 12;
	localparam int COUNT_BITS      = 4;
	localparam int SUM_EXTRA_BITS  = 4;
	localparam int TRIM_SHIFT      = 3;

endpackage

[design/tmot_track.sv]
// block trackers: two largest, two smallest, running sum and sample count
module tmot_track #(
	parameter int SAMPLE_BITS = tmot_pkg::SAMPLE_BITS_DEF,
	localparam int SUM_BITS = SAMPLE_BITS + tmot_pkg::SUM_EXTRA_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   upd,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   done,
	output logic [SAMPLE_BITS-1:0] largest_n,
	output logic [SAMPLE_BITS-1:0] second_largest_n,
	output logic [SAMPLE_BITS-1:0] smallest_n,
	output logic [SAMPLE_BITS-1:0] second_smallest_n,
	output logic [SUM_BITS-1:0]    sum_n
);

	localparam int CB = tmot_pkg::COUNT_BITS;
	localparam logic [CB-1:0] LAST_CNT = CB'(tmot_pkg::BLOCK_LEN - 1);

	logic [SAMPLE_BITS-1:0] largest_q;
	logic [SAMPLE_BITS-1:0] second_largest_q;
	logic [SAMPLE_BITS-1:0] smallest_q;
	logic [SAMPLE_BITS-1:0] second_smallest_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [CB-1:0]          count_q;

	always_comb begin
		largest_n         = largest_q;
		second_largest_n  = second_largest_q;
		smallest_n        = smallest_q;
		second_smallest_n = second_smallest_q;
		if (sample > largest_q) begin
			second_largest_n = largest_q;
			largest_n        = sample;
		end else if (sample > second_largest_q) begin
			second_largest_n = sample;
		end
		if (sample < smallest_q) begin
			second_smallest_n = smallest_q;
			smallest_n        = sample;
		end else if (sample < second_smallest_q) begin
			second_smallest_n = sample;
		end
		sum_n = sum_q + SUM_BITS'(sample);
		done  = (count_q == LAST_CNT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			largest_q         <= '0;
			second_largest_q  <= '0;
			smallest_q        <= '1;
			second_smallest_q <= '1;
			sum_q             <= '0;
			count_q           <= '0;
		end else if (upd) begin
			if (done) begin
				// block complete: start over
				largest_q         <= '0;
				second_largest_q  <= '0;
				smallest_q        <= '1;
				second_smallest_q <= '1;
				sum_q             <= '0;
				count_q           <= '0;
			end else begin
				largest_q         <= largest_n;
				second_largest_q  <= second_largest_n;
				smallest_q        <= smallest_n;
				second_smallest_q <= second_smallest_n;
				sum_q             <= sum_n;
				count_q           <= count_q + CB'(1);
			end
		end
	end

endmodule

[design/trimmed_mean_of_twelve_unit.sv]
// top level of the trimmed mean of twelve unit
//
// channel   dir   fields (tdata, low bit up)        handshake
// s_*       in    sample                             s_tvalid & s_tready
// m_*       out   average                            m_tvalid & m_tready
//
// one sample is accepted every cycle unless input stalls; the tracker update is registered
// a result passes the input register, stage two and the output register after the twelfth sample of a block is taken
// arst_n clears all trackers, the sample count and every valid flag
// a waiting result does not stop input; input stalls only when a finished
// block finds one result held in stage two and another not taken at the output
module trimmed_mean_of_twelve_unit #(
	parameter int SAMPLE_BITS = tmot_pkg::SAMPLE_BITS_DEF,
	localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_BITS-1:0] s_tdata,  // sample
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DATA_BITS-1:0] m_tdata   // average
);

	localparam int SUM_BITS = SAMPLE_BITS + tmot_pkg::SUM_EXTRA_BITS;

	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   vld_s1;

	logic                   done;
	logic [SAMPLE_BITS-1:0] largest_n;
	logic [SAMPLE_BITS-1:0] second_largest_n;
	logic [SAMPLE_BITS-1:0] smallest_n;
	logic [SAMPLE_BITS-1:0] second_smallest_n;
	logic [SUM_BITS-1:0]    sum_n;

	logic [SAMPLE_BITS-1:0] largest_s2;
	logic [SAMPLE_BITS-1:0] second_largest_s2;
	logic [SAMPLE_BITS-1:0] smallest_s2;
	logic [SAMPLE_BITS-1:0] second_smallest_s2;
	logic [SUM_BITS-1:0]    sum_s2;
	logic                   vld_s2;

	logic [SAMPLE_BITS-1:0] average_q;
	logic                   out_vld_q;

	logic                   s2_move;
	logic                   s1_adv;
	logic                   upd;
	logic [SUM_BITS-1:0]    drop;
	logic [SUM_BITS-1:0]    trimmed;
	logic [SUM_BITS-1:0]    shifted;

	assign s2_move  = !out_vld_q || m_tready;
	assign s1_adv   = !(done && vld_s2 && !s2_move);
	assign upd      = vld_s1 && s1_adv;
	assign s_tready = !vld_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= s_tdata[SAMPLE_BITS-1:0];
		end
	end

	tmot_track #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_track (
		.clk              (clk),
		.arst_n           (arst_n),
		.upd              (upd),
		.sample           (sample_s1),
		.done             (done),
		.largest_n        (largest_n),
		.second_largest_n (second_largest_n),
		.smallest_n       (smallest_n),
		.second_smallest_n(second_smallest_n),
		.sum_n            (sum_n)
	);

	// final block values wait here for the trim arithmetic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (upd && done) begin
			vld_s2 <= 1'b1;
		end else if (s2_move) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && done) begin
			largest_s2         <= largest_n;
			second_largest_s2  <= second_largest_n;
			smallest_s2        <= smallest_n;
			second_smallest_s2 <= second_smallest_n;
			sum_s2             <= sum_n;
		end
	end

	always_comb begin
		drop = (SUM_BITS'(largest_s2) + SUM_BITS'(second_largest_s2))
			+ (SUM_BITS'(smallest_s2) + SUM_BITS'(second_smallest_s2));
		trimmed = sum_s2 - drop;
		shifted = trimmed >> tmot_pkg::TRIM_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s2_move) begin
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move && vld_s2) begin
			average_q <= shifted[SAMPLE_BITS-1:0];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = DATA_BITS'(average_q);

endmodule

[tb/sv/tmot_checker.sv]
// checker for the trimmed mean of twelve unit: tracks blocks, predicts averages, compares
`timescale 1ns / 1ps
module tmot_checker
	import tmot_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [DATA_BITS-1:0] s_tdata,  // sample
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [DATA_BITS-1:0] m_tdata,  // average
	output int                   mismatches,
	output int                   pending,
	output int                   blocks_checked
);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SAMPLE_BITS+SUM_EXTRA_BITS-1:0] sum_t;

	sample_t                top_first, top_second, bottom_first, bottom_second;
	sum_t                   block_sum;
	logic [COUNT_BITS-1:0]  block_fill;
	sample_t                average_q[$];
	int                     err_count;
	int                     done_count;

	function automatic void note_error(input string what, input sample_t want,
			input sample_t got);
		if (err_count < 10)
			$display("mismatch: %s, expected average %0d, got %0d", what, want, got);
		err_count++;
	endfunction

	function automatic void clear_trackers();
		top_first     = '0;
		top_second    = '0;
		bottom_first  = '1;
		bottom_second = '1;
		block_sum     = '0;
		block_fill    = '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		sample_t s;
		sample_t want;
		sum_t    kept;
		if (!arst_n) begin
			clear_trackers();
			average_q.delete();
			err_count  = 0;
			done_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (average_q.size() == 0) begin
					note_error("word with nothing expected", '0, m_tdata[SAMPLE_BITS-1:0]);
				end else begin
					want = average_q.pop_front();
					if (m_tdata[SAMPLE_BITS-1:0] !== want)
						note_error("wrong average", want, m_tdata[SAMPLE_BITS-1:0]);
				end
				done_count++;
			end
			if (s_tvalid && s_tready) begin
				// upper padding bits of the word are ignored
				s = s_tdata[SAMPLE_BITS-1:0];
				if (s > top_first) begin
					top_second = top_first;
					top_first  = s;
				end else if (s > top_second) begin
					top_second = s;
				end
				if (s < bottom_first) begin
					bottom_second = bottom_first;
					bottom_first  = s;
				end else if (s < bottom_second) begin
					bottom_second = s;
				end
				block_sum  = block_sum + s;
				block_fill = block_fill + 1'b1;
				if (block_fill == BLOCK_LEN) begin
					kept = block_sum - top_first - top_second - bottom_first - bottom_second;
					average_q.push_back(sample_t'(kept >> TRIM_SHIFT));
					clear_trackers();
				end
			end
		end
		mismatches     <= err_count;
		pending        <= average_q.size();
		blocks_checked <= done_count;
	end

endmodule

[tb/sv/tb_trimmed_mean_of_twelve_unit.sv]
// testbench top for the trimmed mean of twelve unit: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_trimmed_mean_of_twelve_unit;
	import tmot_pkg::*;

	localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
	localparam int DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic [DATA_BITS-1:0] s_tdata = '0;
	logic                 m_tready = 1'b0;
	wire                  s_tready;
	wire                  m_tvalid;
	wire  [DATA_BITS-1:0] m_tdata;

	int mismatches;
	int pending;
	int blocks_checked;
	int sent = 0;
	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	bit hold_req = 1'b0;

	always #5 clk = ~clk;

	trimmed_mean_of_twelve_unit #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	tmot_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatches     (mismatches),
		.pending        (pending),
		.blocks_checked (blocks_checked)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic put_word(input logic [DATA_BITS-1:0] w);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		sent++;
		if (tx_idle_en) begin
			gap = pick_gap();
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// one block of twelve samples shaped by a randomly chosen pattern
	task automatic put_block();
		int style, i, smp, center, step, base;
		int pool[3];
		logic [DATA_BITS-1:0] w;
		style  = $urandom_range(0, 9);
		center = $urandom_range(32, SAMPLE_MAX - 32);
		step   = $urandom_range(0, 340);
		base   = $urandom_range(0, SAMPLE_MAX - 11 * step);
		for (i = 0; i < 3; i++)
			pool[i] = $urandom_range(0, SAMPLE_MAX);
		for (i = 0; i < BLOCK_LEN; i++) begin
			case (style)
				4: smp = center - 32 + $urandom_range(0, 64);
				5: smp = base + i * step;
				6: smp = base + (BLOCK_LEN - 1 - i) * step;
				7: smp = pool[$urandom_range(0, 2)];
				8: smp = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
				default: smp = $urandom_range(0, SAMPLE_MAX);
			endcase
			w = DATA_BITS'($urandom());
			w[SAMPLE_BITS-1:0] = smp[SAMPLE_BITS-1:0];
			// padding bits stay zero except for an occasional stray word
			if ($urandom_range(0, 7) != 0)
				w[DATA_BITS-1:SAMPLE_BITS] = '0;
			put_word(w);
		end
	endtask

	task automatic put_blocks(input int count);
		repeat (count) put_block();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin : rx
		int stall_left;
		int held;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				for (held = 0; held < 400; held++) @(posedge clk);
				hold_req <= 1'b0;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle_en && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin : stim
		int i;
		int waited;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// full-scale block with stray padding bits set
		for (i = 0; i < BLOCK_LEN; i++)
			put_word('1);
		// alternating full scale and zero: ties on both trackers
		for (i = 0; i < BLOCK_LEN; i++)
			put_word(i[0] ? DATA_BITS'(0) : DATA_BITS'(SAMPLE_MAX));
		s_tvalid <= 1'b0;
		@(posedge clk);

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		put_blocks(60);

		// long receiver hold-off while samples keep coming back to back
		tx_idle_en = 1'b0;
		hold_req <= 1'b1;
		@(posedge clk);
		put_blocks(5);
		drain();

		rx_idle_en = 1'b0;
		put_blocks(20);

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		put_blocks(59);

		@(posedge clk);
		for (waited = 0; pending != 0 && waited < 20000; waited++)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("run: %0d samples sent, %0d averages compared", sent, blocks_checked);
		$display("run: full-scale, tie and random-pattern blocks under stalls and a long hold-off");
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
